[rtl/core/djq_pkg.sv]
// shared types and constants for the delayed job queue
`timescale 1ns / 1ps

package djq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int DELAY_BITS  = 16;
    localparam int FIELD_W     = 16;
    localparam int OCC_W       = 5;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUB_W       = (DELAY_BITS > FIELD_W) ? DELAY_BITS : FIELD_W;

    typedef logic [DELAY_BITS-1:0] delay_t;
    typedef logic [FIELD_W-1:0]    job_t;
    typedef logic [CNT_W-1:0]      count_t;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_TICK   = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP,
        CELL_TICK
    } cell_op_t;

    // broadcast to every cell of the row
    typedef struct packed {
        cell_op_t         op;
        delay_t           delay;
        job_t             job;
        logic [FIELD_W-1:0] elapsed;
        logic             head_before;
    } cell_cmd_t;

endpackage

[rtl/core/djq_if.sv]
// request and result channel interfaces
`timescale 1ns / 1ps

interface djq_req_if import djq_pkg::*;;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [FIELD_W-1:0] delay;
    logic [FIELD_W-1:0] elapsed;

    modport source (output valid, action, delay, elapsed, input ready);
    modport sink   (input valid, action, delay, elapsed, output ready);
endinterface

interface djq_res_if import djq_pkg::*;;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic               head_valid;
    logic [FIELD_W-1:0] head_job;
    logic [FIELD_W-1:0] head_delay;
    logic [OCC_W-1:0]   occupancy;

    modport source (output valid, status, head_valid, head_job, head_delay, occupancy,
                    input ready);
    modport sink   (input valid, status, head_valid, head_job, head_delay, occupancy,
                    output ready);
endinterface

[rtl/core/djq_cell.sv]
// one slot of the sorted queue, shifting left or right with its neighbours
`timescale 1ns / 1ps

module djq_cell
    import djq_pkg::*;
(
    input  logic      clk,
    input  cell_cmd_t cmd,
    input  logic      valid,
    input  logic      left_ge,
    input  delay_t    left_delay,
    input  job_t      left_job,
    input  delay_t    right_delay,
    input  job_t      right_job,
    output logic      ge,
    output delay_t    delay,
    output job_t      job
);

    delay_t delay_reg;
    job_t   job_reg;
    delay_t delay_next;
    job_t   job_next;
    logic [SUB_W-1:0] cur_ext;
    logic [SUB_W-1:0] ela_ext;

    // empty slots sort after everything
    assign ge = !valid || cmd.head_before || (delay_reg > cmd.delay);

    assign cur_ext = SUB_W'(delay_reg);
    assign ela_ext = SUB_W'(cmd.elapsed);

    always_comb
    begin
        delay_next = delay_reg;
        job_next   = job_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                if (ge)
                begin
                    if (left_ge)
                    begin
                        delay_next = left_delay;
                        job_next   = left_job;
                    end
                    else
                    begin
                        delay_next = cmd.delay;
                        job_next   = cmd.job;
                    end
                end
            end
            CELL_POP:
            begin
                delay_next = right_delay;
                job_next   = right_job;
            end
            CELL_TICK:
            begin
                delay_next = (cur_ext > ela_ext) ? DELAY_BITS'(cur_ext - ela_ext) : '0;
            end
            default:
            begin
                delay_next = delay_reg;
                job_next   = job_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        delay_reg <= delay_next;
        job_reg   <= job_next;
    end

    assign delay = delay_reg;
    assign job   = job_reg;

endmodule

[rtl/core/delayed_job_queue_unit.sv]
// delayed job queue: row of sorted slots with request and result channels
//
// Usage: each request carries an action (insert, remove head, tick), a delay
// for an insert and an elapsed count for a tick. Every request gives exactly
// one result: a status, the head job and its remaining delay, and occupancy
// after the request. Inserts take the next sequence number; an insert into a
// full queue is dropped with a full status, a remove on an empty queue
// reports an empty status.
// The result is registered the cycle after its request is taken. Unless the
// result stalls, one request is taken per cycle: every slot compares against
// the new delay at once and moves in the same edge, so the rate is set by the
// compare and shift in the slot row. The result is held in an output register;
// while the receiver stalls it stays there and no further request is taken,
// and a request is taken in the same cycle that the waiting result is collected.
// Reset clears the occupancy, the sequence counter and the result register;
// slot contents are not reset and are only read below the occupancy.
`timescale 1ns / 1ps

module delayed_job_queue_unit
    import djq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    djq_req_if.sink   request,
    djq_res_if.source result
);

    count_t    count_reg;
    count_t    count_next;
    job_t      seq_reg;
    job_t      seq_next;
    logic      res_valid_reg;
    logic      res_valid_next;
    status_t   status_reg;
    status_t   status_next;
    cell_cmd_t cmd;
    logic      accept;
    delay_t    new_delay;

    delay_t cell_delay [QUEUE_DEPTH];
    job_t   cell_job   [QUEUE_DEPTH];
    logic   cell_ge    [QUEUE_DEPTH];

    assign request.ready = !res_valid_reg || result.ready;
    assign accept        = request.valid && request.ready;
    assign new_delay     = DELAY_BITS'(request.delay);

    always_comb
    begin
        count_next     = count_reg;
        seq_next       = seq_reg;
        status_next    = status_reg;
        res_valid_next = res_valid_reg && !result.ready;
        cmd.op         = CELL_HOLD;
        cmd.delay      = new_delay;
        cmd.job        = seq_reg;
        cmd.elapsed    = request.elapsed;
        // new job goes in front when the queue is empty or it is not later than the head
        cmd.head_before = (count_reg == '0) || (new_delay <= cell_delay[0]);
        if (accept)
        begin
            res_valid_next = 1'b1;
            status_next    = ST_DONE;
            case (request.action)
                ACT_INSERT:
                begin
                    if (count_reg == CNT_W'(QUEUE_DEPTH))
                        status_next = ST_FULL;
                    else
                    begin
                        cmd.op     = CELL_INSERT;
                        count_next = count_reg + 1'b1;
                        seq_next   = seq_reg + 1'b1;
                    end
                end
                ACT_REMOVE:
                begin
                    if (count_reg == '0)
                        status_next = ST_EMPTY;
                    else
                    begin
                        cmd.op     = CELL_POP;
                        count_next = count_reg - 1'b1;
                    end
                end
                ACT_TICK:
                begin
                    cmd.op = CELL_TICK;
                end
                default:
                begin
                    cmd.op = CELL_HOLD;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            seq_reg       <= '0;
            res_valid_reg <= 1'b0;
            status_reg    <= ST_DONE;
        end
        else
        begin
            count_reg     <= count_next;
            seq_reg       <= seq_next;
            res_valid_reg <= res_valid_next;
            status_reg    <= status_next;
        end
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic   left_ge;
        delay_t left_delay;
        job_t   left_job;
        delay_t right_delay;
        job_t   right_job;

        if (i == 0)
        begin : g_first
            assign left_ge    = 1'b0;
            assign left_delay = '0;
            assign left_job   = '0;
        end
        else
        begin : g_mid
            assign left_ge    = cell_ge[i-1];
            assign left_delay = cell_delay[i-1];
            assign left_job   = cell_job[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_delay = '0;
            assign right_job   = '0;
        end
        else
        begin : g_inner
            assign right_delay = cell_delay[i+1];
            assign right_job   = cell_job[i+1];
        end

        djq_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .valid       (CNT_W'(i) < count_reg),
            .left_ge     (left_ge),
            .left_delay  (left_delay),
            .left_job    (left_job),
            .right_delay (right_delay),
            .right_job   (right_job),
            .ge          (cell_ge[i]),
            .delay       (cell_delay[i]),
            .job         (cell_job[i])
        );
    end

    assign result.valid      = res_valid_reg;
    assign result.status     = status_reg;
    assign result.head_valid = (count_reg != '0);
    assign result.head_job   = (count_reg != '0) ? cell_job[0] : '0;
    assign result.head_delay = (count_reg != '0) ? FIELD_W'(cell_delay[0]) : '0;
    assign result.occupancy  = OCC_W'(count_reg);

endmodule

[rtl/core/djq_checker.sv]
// port-level checks on the delayed job queue results
`timescale 1ns / 1ps

module djq_checker
    import djq_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_ready,
    input logic [1:0]         status,
    input logic               head_valid,
    input logic [FIELD_W-1:0] head_job,
    input logic [FIELD_W-1:0] head_delay,
    input logic [OCC_W-1:0]   occupancy
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> occupancy <= OCC_W'(QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> head_valid == (occupancy != '0))
        else $error("head valid disagrees with occupancy");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !head_valid |-> head_job == '0 && head_delay == '0)
        else $error("empty queue shows a head");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == ST_FULL |-> occupancy == OCC_W'(QUEUE_DEPTH))
        else $error("full status with room left");

endmodule

bind delayed_job_queue_unit djq_checker u_djq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .status     (result.status),
    .head_valid (result.head_valid),
    .head_job   (result.head_job),
    .head_delay (result.head_delay),
    .occupancy  (result.occupancy)
);

[tb/sv/tb_delayed_job_queue_unit.sv]
// testbench for the delayed job queue: directed table, then random requests checked by a predictor
`timescale 1ns / 1ps

module tb_delayed_job_queue_unit;
    import djq_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 450;
    localparam int CALM_TAIL       = 60;
    localparam int HOLD_OFF_AT     = 150;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        status_t            status;
        logic               head_valid;
        job_t               head_job;
        logic [FIELD_W-1:0] head_delay;
        logic [OCC_W-1:0]   occupancy;
    } queue_report_t;

    typedef struct {
        logic [1:0]         action;
        logic [FIELD_W-1:0] delay;
        logic [FIELD_W-1:0] elapsed;
        bit                 typed;
        queue_report_t      report;
    } queue_request_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    djq_req_if req_ch ();
    djq_res_if res_ch ();

    delayed_job_queue_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .result  (res_ch)
    );

    // predicted queue contents, sorted by remaining delay
    delay_t held_delay [QUEUE_DEPTH];
    job_t   held_job   [QUEUE_DEPTH];
    int     held_count  = 0;
    job_t   next_job_id = '0;

    queue_report_t  expected_reports [$];
    queue_request_t directed_rows [$];
    bit             row_typed  = 1'b0;
    queue_report_t  row_report = '0;
    bit             idling_on  = 1'b1;
    int             accepted_requests = 0;
    int             error_count  = 0;
    int             quiet_cycles = 0;
    bit             req_fire;
    bit             res_fire;
    queue_report_t  got_report;
    queue_report_t  want_report;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic queue_report_t queue_step_report(input logic [1:0] act,
                                                        input logic [FIELD_W-1:0] dly,
                                                        input logic [FIELD_W-1:0] elap);
        int            pos;
        int            i;
        delay_t        d;
        queue_report_t rep;
        d = delay_t'(dly);
        rep = '0;
        rep.status = ST_DONE;
        case (act)
            ACT_INSERT:
            begin
                if (held_count >= QUEUE_DEPTH)
                    rep.status = ST_FULL;
                else
                begin
                    // ties with the head go in front, other ties go behind
                    if (held_count == 0 || d <= held_delay[0])
                        pos = 0;
                    else
                    begin
                        pos = 1;
                        while (pos < held_count && held_delay[pos] <= d)
                            pos++;
                    end
                    for (i = held_count; i > pos; i--)
                    begin
                        held_delay[i] = held_delay[i-1];
                        held_job[i]   = held_job[i-1];
                    end
                    held_delay[pos] = d;
                    held_job[pos]   = next_job_id;
                    next_job_id++;
                    held_count++;
                end
            end
            ACT_REMOVE:
            begin
                if (held_count == 0)
                    rep.status = ST_EMPTY;
                else
                begin
                    for (i = 1; i < held_count; i++)
                    begin
                        held_delay[i-1] = held_delay[i];
                        held_job[i-1]   = held_job[i];
                    end
                    held_count--;
                end
            end
            ACT_TICK:
            begin
                for (i = 0; i < held_count; i++)
                    if (SUB_W'(held_delay[i]) > SUB_W'(elap))
                        held_delay[i] = held_delay[i] - delay_t'(elap);
                    else
                        held_delay[i] = '0;
            end
            default: ;
        endcase
        if (held_count > 0)
        begin
            rep.head_valid = 1'b1;
            rep.head_job   = held_job[0];
            rep.head_delay = FIELD_W'(held_delay[0]);
        end
        rep.occupancy = OCC_W'(held_count);
        return rep;
    endfunction

    task automatic offer_request(input queue_request_t r);
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 15)) @(negedge clk);
        end
        @(negedge clk);
        row_typed  = r.typed;
        row_report = r.report;
        req_ch.valid   <= 1'b1;
        req_ch.action  <= r.action;
        req_ch.delay   <= r.delay;
        req_ch.elapsed <= r.elapsed;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // request acceptance, result checking and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_fire = req_ch.valid && req_ch.ready;
            res_fire = res_ch.valid && res_ch.ready;
            if (req_fire)
            begin
                want_report = queue_step_report(req_ch.action, req_ch.delay, req_ch.elapsed);
                if (row_typed)
                    want_report = row_report;
                expected_reports.push_back(want_report);
                accepted_requests++;
            end
            if (res_fire)
            begin
                got_report = queue_report_t'({res_ch.status, res_ch.head_valid,
                                              res_ch.head_job, res_ch.head_delay,
                                              res_ch.occupancy});
                if (expected_reports.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("unexpected result: st=%0d hv=%0d job=%h dly=%h occ=%0d",
                                 got_report.status, got_report.head_valid,
                                 got_report.head_job, got_report.head_delay,
                                 got_report.occupancy);
                end
                else
                begin
                    want_report = expected_reports.pop_front();
                    if (got_report.status !== want_report.status
                        || got_report.head_valid !== want_report.head_valid
                        || got_report.head_job !== want_report.head_job
                        || got_report.head_delay !== want_report.head_delay
                        || got_report.occupancy !== want_report.occupancy)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                        begin
                            $write("mismatch: want st=%0d hv=%0d job=%h dly=%h occ=%0d,",
                                   want_report.status, want_report.head_valid,
                                   want_report.head_job, want_report.head_delay,
                                   want_report.occupancy);
                            $display(" got st=%0d hv=%0d job=%h dly=%h occ=%0d",
                                     got_report.status, got_report.head_valid,
                                     got_report.head_job, got_report.head_delay,
                                     got_report.occupancy);
                        end
                    end
                end
            end
            quiet_cycles = (req_fire || res_fire) ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // result side: random stalls and one long hold-off
    initial
    begin : result_sink
        bit held_off;
        held_off = 1'b0;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_off && accepted_requests >= HOLD_OFF_AT)
            begin
                held_off = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge clk);
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(10, 40)) @(negedge clk);
            end
        end
    end

    initial
    begin : stimulus
        queue_request_t r;
        int             n;
        int             pick;
        int             insert_share;
        insert_share = 50;
        req_ch.valid   = 1'b0;
        req_ch.action  = ACT_INSERT;
        req_ch.delay   = '0;
        req_ch.elapsed = '0;

        // empty queue first, then fill to the brim and overflow
        directed_rows.push_back('{ACT_REMOVE, 16'h0000, 16'h0000, 1'b1,
                                  '{ST_EMPTY, 1'b0, 16'h0000, 16'h0000, 5'd0}});
        directed_rows.push_back('{ACT_TICK,   16'h0000, 16'hFFFF, 1'b1,
                                  '{ST_DONE, 1'b0, 16'h0000, 16'h0000, 5'd0}});
        directed_rows.push_back('{ACT_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1,
                                  '{ST_DONE, 1'b0, 16'h0000, 16'h0000, 5'd0}});
        directed_rows.push_back('{ACT_INSERT, 16'hFFFF, 16'h0000, 1'b1,
                                  '{ST_DONE, 1'b1, 16'h0000, 16'hFFFF, 5'd1}});
        directed_rows.push_back('{ACT_INSERT, 16'h0000, 16'hFFFF, 1'b1,
                                  '{ST_DONE, 1'b1, 16'h0001, 16'h0000, 5'd2}});
        // equal to the head: goes in front
        directed_rows.push_back('{ACT_INSERT, 16'h0000, 16'h0000, 1'b1,
                                  '{ST_DONE, 1'b1, 16'h0002, 16'h0000, 5'd3}});
        directed_rows.push_back('{ACT_INSERT, 16'h8000, 16'h0000, 1'b0, '0});
        directed_rows.push_back('{ACT_INSERT, 16'h8000, 16'h0000, 1'b0, '0});
        directed_rows.push_back('{ACT_INSERT, 16'h5555, 16'hAAAA, 1'b0, '0});
        directed_rows.push_back('{ACT_INSERT, 16'hAAAA, 16'h5555, 1'b0, '0});
        directed_rows.push_back('{ACT_INSERT, 16'h0001, 16'h0000, 1'b0, '0});
        directed_rows.push_back('{ACT_INSERT, 16'h7FFF, 16'h0000, 1'b0, '0});
        directed_rows.push_back('{ACT_INSERT, 16'h8001, 16'h0000, 1'b0, '0});
        directed_rows.push_back('{ACT_INSERT, 16'h0100, 16'h0000, 1'b0, '0});
        directed_rows.push_back('{ACT_INSERT, 16'h00FF, 16'h0000, 1'b0, '0});
        directed_rows.push_back('{ACT_INSERT, 16'hFFFE, 16'h0000, 1'b0, '0});
        directed_rows.push_back('{ACT_INSERT, 16'h1234, 16'h0000, 1'b0, '0});
        directed_rows.push_back('{ACT_INSERT, 16'h4321, 16'h0000, 1'b0, '0});
        directed_rows.push_back('{ACT_INSERT, 16'h5555, 16'h0000, 1'b0, '0});
        // full: dropped, no sequence number used
        directed_rows.push_back('{ACT_INSERT, 16'h1234, 16'h0000, 1'b1,
                                  '{ST_FULL, 1'b1, 16'h0002, 16'h0000, 5'd16}});
        directed_rows.push_back('{ACT_TICK,   16'h0000, 16'h0001, 1'b0, '0});
        // tick past every delay saturates all of them
        directed_rows.push_back('{ACT_TICK,   16'h0000, 16'hFFFF, 1'b1,
                                  '{ST_DONE, 1'b1, 16'h0002, 16'h0000, 5'd16}});
        directed_rows.push_back('{ACT_UNUSED, 16'h0000, 16'h0000, 1'b0, '0});
        directed_rows.push_back('{ACT_REMOVE, 16'h0000, 16'h0000, 1'b0, '0});
        directed_rows.push_back('{ACT_INSERT, 16'h0000, 16'h0000, 1'b0, '0});

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer_request(directed_rows[i]);

        for (n = 0; n < RANDOM_REQUESTS; n++)
        begin
            // phases lean towards filling or draining the queue
            if (n % 40 == 0)
                case ($urandom_range(0, 3))
                    0: insert_share = 25;
                    1: insert_share = 50;
                    2: insert_share = 70;
                    default: insert_share = 90;
                endcase
            if (n == RANDOM_REQUESTS - CALM_TAIL)
                idling_on = 1'b0;
            r.typed  = 1'b0;
            r.report = '0;
            pick = $urandom_range(0, 99);
            if (pick < 3)
                r.action = ACT_UNUSED;
            else if (pick < 3 + insert_share)
                r.action = ACT_INSERT;
            else if (pick % 3 == 0)
                r.action = ACT_TICK;
            else
                r.action = ACT_REMOVE;
            case ($urandom_range(0, 4))
                0, 1: r.delay = FIELD_W'($urandom);
                2: r.delay = FIELD_W'($urandom_range(0, 15));
                3: r.delay = (held_count > 0)
                           ? FIELD_W'(held_delay[$urandom_range(0, held_count - 1)])
                           : FIELD_W'($urandom);
                default: r.delay = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
            endcase
            case ($urandom_range(0, 7))
                0, 1, 2, 3: r.elapsed = FIELD_W'($urandom_range(0, 300));
                4: r.elapsed = 16'h0000;
                5: r.elapsed = 16'hFFFF;
                default: r.elapsed = FIELD_W'($urandom);
            endcase
            offer_request(r);
        end
        @(negedge clk);
        req_ch.valid <= 1'b0;

        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (error_count == 0 && expected_reports.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
rtl/core/djq_pkg.sv
rtl/core/djq_if.sv
rtl/core/djq_cell.sv
rtl/core/delayed_job_queue_unit.sv
rtl/core/djq_checker.sv
tb/sv/tb_delayed_job_queue_unit.sv
